// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define NBCC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

`define NBCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define NBCC_ASSERT(label, prop)

`define NBCC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/nbcc_pkg.sv =====
package nbcc_pkg;

	localparam int STRIP_LEDS = 8;
	localparam int LED_W = (STRIP_LEDS > 1) ? $clog2(STRIP_LEDS) : 1;
	localparam logic [LED_W-1:0] LED_LAST = LED_W'(STRIP_LEDS - 1);

	localparam logic [1:0] CFG_MAX_BRIGHTNESS = 2'd0;
	localparam logic [1:0] CFG_SPEED_LEVEL    = 2'd1;
	localparam logic [1:0] CFG_FIRST_LED      = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_SCALE,
		ST_WAIT,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		CH_G,
		CH_R,
		CH_B
	} chan_t;

	typedef struct packed {
		logic       start;
		logic [7:0] chan;
		logic [7:0] level;
		logic [7:0] peak;
	} scl_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] result;
	} scl_rsp_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	function automatic logic [5:0] update_interval(input logic [3:0] spd);
		logic [5:0] iv;
		case (spd)
			4'd0: iv = 6'd45;
			4'd1: iv = 6'd20;
			4'd2: iv = 6'd29;
			4'd3: iv = 6'd20;
			default: iv = 6'd15;
		endcase
		return iv;
	endfunction

	function automatic rgb_t palette(input logic [2:0] idx, input logic [7:0] m,
			input logic [3:0] spd);
		logic [7:0]  off;
		logic [7:0]  d;
		logic [15:0] p;
		logic [7:0]  m5;
		logic [7:0]  m2;
		rgb_t        c;
		off = {3'b000, spd, 1'b0};
		d = (m > off) ? (m - off) : 8'd0;
		// m/5 as m*205 >> 10, exact for 8-bit m
		p = 16'(m) * 16'd205;
		m5 = 8'(p >> 10);
		m2 = {1'b0, m[7:1]};
		case (idx)
			3'd0: c = '{r: m, g: 8'd0, b: 8'd0};
			3'd1: c = '{r: m, g: m5, b: 8'd0};
			3'd2: c = '{r: d, g: d, b: 8'd0};
			3'd3: c = '{r: 8'd0, g: m, b: 8'd0};
			3'd4: c = '{r: 8'd0, g: d, b: d};
			3'd5: c = '{r: 8'd0, g: 8'd0, b: m};
			3'd6: c = '{r: d, g: 8'd0, b: d};
			default: c = '{r: m2, g: m2, b: m2};
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/neon_breathing_color_cycler.sv =====
// Neon breathing color cycler: each request carries a millisecond time stamp;
// the brightness takes one step when the speed-level interval has elapsed,
// then the block emits STRIP_LEDS results, one per LED, carrying the palette
// color scaled by level / max_brightness (green on chan_a). An item passes
// through the brightness step, then each of the three channels in turn goes
// through the shared multiply and 16-step serial divide unit, then the LED
// results go out, one per cycle while out_stall is low.
// in_stall is high for that whole time. Configuration writes are always
// taken (cfg_ready is tied high) and must arrive only while the block is idle.
`include "assert_macros.svh"

module neon_breathing_color_cycler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  led_num,
	output logic [7:0]  chan_a,
	output logic [7:0]  chan_b,
	output logic [7:0]  chan_c,
	output logic        last_led,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	nbcc_pkg::state_t state_q, state_d;
	nbcc_pkg::chan_t  chan_q;

	logic [7:0]  max_q;
	logic [3:0]  speed_q;
	logic [7:0]  first_q;

	logic [31:0] now_q;
	logic [31:0] last_time_q;
	logic [2:0]  pal_q;
	logic [7:0]  level_q;
	logic        ramp_up_q;

	logic [7:0]  g_q;
	logic [7:0]  r_q;
	logic [7:0]  b_q;
	logic [nbcc_pkg::LED_W-1:0] pos_q;

	logic               accept;
	logic               emit_take;
	logic [31:0]        elapsed;
	logic               due;
	logic [7:0]         level_inc;
	nbcc_pkg::rgb_t     color;
	nbcc_pkg::scl_req_t req;
	nbcc_pkg::scl_rsp_t rsp;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign emit_take = out_valid && !out_stall;
	assign elapsed   = now_q - last_time_q;
	assign due       = elapsed >= {26'd0, nbcc_pkg::update_interval(speed_q)};
	assign level_inc = level_q + 8'd1;
	assign color     = nbcc_pkg::palette(pal_q, max_q, speed_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= 8'hff;
			speed_q <= '0;
			first_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				nbcc_pkg::CFG_MAX_BRIGHTNESS: max_q <= cfg_data;
				nbcc_pkg::CFG_SPEED_LEVEL: speed_q <= cfg_data[3:0];
				nbcc_pkg::CFG_FIRST_LED: first_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nbcc_pkg::ST_IDLE: if (in_valid) state_d = nbcc_pkg::ST_STEP;
			nbcc_pkg::ST_STEP: state_d = nbcc_pkg::ST_SCALE;
			nbcc_pkg::ST_SCALE: state_d = nbcc_pkg::ST_WAIT;
			nbcc_pkg::ST_WAIT: begin
				if (rsp.done)
					state_d = (chan_q == nbcc_pkg::CH_B) ? nbcc_pkg::ST_EMIT
						: nbcc_pkg::ST_SCALE;
			end
			nbcc_pkg::ST_EMIT: begin
				if (!out_stall && pos_q == nbcc_pkg::LED_LAST)
					state_d = nbcc_pkg::ST_IDLE;
			end
			default: state_d = nbcc_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = (state_q != nbcc_pkg::ST_IDLE);
		out_valid = (state_q == nbcc_pkg::ST_EMIT);
		req.start = (state_q == nbcc_pkg::ST_SCALE);
		req.level = level_q;
		req.peak  = max_q;
		case (chan_q)
			nbcc_pkg::CH_G: req.chan = color.g;
			nbcc_pkg::CH_R: req.chan = color.r;
			nbcc_pkg::CH_B: req.chan = color.b;
			default: req.chan = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nbcc_pkg::ST_IDLE;
			chan_q      <= nbcc_pkg::CH_G;
			pos_q       <= '0;
			last_time_q <= '0;
			pal_q       <= '0;
			level_q     <= '0;
			ramp_up_q   <= 1'b1;
		end else begin
			state_q <= state_d;
			case (state_q)
				nbcc_pkg::ST_STEP: begin
					chan_q <= nbcc_pkg::CH_G;
					pos_q  <= '0;
					if (due) begin
						last_time_q <= now_q;
						if (ramp_up_q) begin
							if (level_inc >= max_q) begin
								level_q   <= max_q;
								ramp_up_q <= 1'b0;
							end else begin
								level_q <= level_inc;
							end
						end else if (level_q != 8'd0) begin
							level_q <= level_q - 8'd1;
						end else begin
							ramp_up_q <= 1'b1;
							pal_q     <= pal_q + 3'd1;
						end
					end
				end
				nbcc_pkg::ST_WAIT: begin
					if (rsp.done) begin
						case (chan_q)
							nbcc_pkg::CH_G: chan_q <= nbcc_pkg::CH_R;
							nbcc_pkg::CH_R: chan_q <= nbcc_pkg::CH_B;
							default: chan_q <= nbcc_pkg::CH_G;
						endcase
					end
				end
				nbcc_pkg::ST_EMIT: begin
					if (emit_take && pos_q != nbcc_pkg::LED_LAST)
						pos_q <= pos_q + nbcc_pkg::LED_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			now_q <= now_ms;
		if (state_q == nbcc_pkg::ST_WAIT && rsp.done) begin
			case (chan_q)
				nbcc_pkg::CH_G: g_q <= rsp.result;
				nbcc_pkg::CH_R: r_q <= rsp.result;
				nbcc_pkg::CH_B: b_q <= rsp.result;
				default: ;
			endcase
		end
	end

	nbcc_scaler u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign led_num  = first_q + 8'(pos_q);
	assign chan_a   = g_q;
	assign chan_b   = r_q;
	assign chan_c   = b_q;
	assign last_led = (pos_q == nbcc_pkg::LED_LAST);

	`NBCC_ASSERT(a_no_accept_during_emit, out_valid |-> in_stall)
	`NBCC_ASSERT_NEXT(a_accept_steps, accept, state_q == nbcc_pkg::ST_STEP)
	`NBCC_ASSERT(a_done_in_wait, rsp.done |-> (state_q == nbcc_pkg::ST_WAIT))

endmodule

// ===== hdl/nbcc_scaler.sv =====
`include "assert_macros.svh"

module nbcc_scaler (
	input  logic               clk,
	input  logic               arst_n,
	input  nbcc_pkg::scl_req_t req,
	output nbcc_pkg::scl_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [7:0]  r_q;
	logic [15:0] dq_q;
	logic [7:0]  d_q;
	logic [7:0]  result_q;

	logic [8:0]  rem;
	logic        ge;
	logic [15:0] quot;

	// one restoring division step per cycle while busy
	assign rem  = {r_q, dq_q[15]};
	assign ge   = rem >= {1'b0, d_q};
	assign quot = {dq_q[14:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q <= 16'(req.chan) * 16'(req.level);
			r_q  <= '0;
			d_q  <= req.peak;
		end else if (busy_q) begin
			dq_q <= quot;
			r_q  <= ge ? 8'(rem - {1'b0, d_q}) : rem[7:0];
			if (cnt_q == 4'd15) begin
				if (d_q == 8'd0)
					result_q <= 8'd0;
				else if (quot[15:8] != 8'd0)
					result_q <= 8'hff;
				else
					result_q <= quot[7:0];
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

	`NBCC_ASSERT(a_done_after_busy, done_q |-> $past(busy_q))
	`NBCC_ASSERT_NEXT(a_start_busy, req.start, busy_q)
	`NBCC_ASSERT(a_rem_below_div, (busy_q && d_q != 8'd0) |-> (r_q < d_q))

endmodule
